>>> design/rsob_pkg.sv
package rsob_pkg;

  // source select codes carried on the func field
  typedef enum logic [1:0] {
    FUNC_IMAGE      = 2'd0,
    FUNC_SOLID      = 2'd1,
    FUNC_MASK_BRUSH = 2'd2,
    FUNC_MASK_PAINT = 2'd3
  } func_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_OPACITY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BRUSH_R = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BRUSH_G = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BRUSH_B = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BRUSH_A = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // reciprocals of 255: (x * RECIP16) >> 23 exact below 66052,
  // (x * RECIP24) >> 31 exact below about 16.9 million
  localparam logic [31:0] RECIP16 = 32'd32897;
  localparam logic [47:0] RECIP24 = 48'h808081;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // item fields riding along the alpha stages
  typedef struct packed {
    func_e      func;
    rgb_t       color;
    logic [7:0] mask;
    logic       src_nz;
    pix_t       dst;
  } carry_t;

  // handoff from the alpha stages to the blend stages
  typedef struct packed {
    rgb_t       color;
    pix_t       dst;
    logic [7:0] alpha;
    logic       full;
    logic       act;
  } blend_req_t;

  // floor(x / 255) for x up to 65025
  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * RECIP16;
    return p[30:23];
  endfunction

  // floor(x / 255) for x up to 255 * 255 * 255
  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [47:0] p;
    p = 48'(x) * RECIP24;
    return p[46:31];
  endfunction

endpackage

>>> design/rsob_if.sv
interface rsob_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] mask_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, func, src_red, src_green, src_blue, src_alpha, mask_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, func, src_red, src_green, src_blue, src_alpha, mask_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface rsob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       written;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, written,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, written,
    output ready
  );
endinterface

>>> design/rsob_alpha.sv
module rsob_alpha import rsob_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] opacity_i,
  input  logic [7:0] brush_alpha_i,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  carry_t     s_carry_i,
  input  logic [7:0] s_src_alpha_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output blend_req_t m_req_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  carry_t c1_q, c2_q, c3_q;
  logic [15:0] m1_d, m1_q;
  logic [7:0]  q2_q, q3_q;
  logic [23:0] p3_q;
  logic [15:0] x3_d, x3_q;
  logic [7:0]  a4;
  logic        act4;
  blend_req_t  req_d, req_q;
  logic [7:0]  op_a, op_b;

  // stage advance: a stage moves when empty or when its successor moves
  assign en4 = !v4_q || m_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_ready_o = en1;

  // stage 1 operands of the first alpha product
  always_comb begin
    op_a = s_src_alpha_i;
    op_b = opacity_i;
    case (s_carry_i.func)
      FUNC_IMAGE: begin
        op_a = s_src_alpha_i;
        op_b = opacity_i;
      end
      FUNC_SOLID: begin
        op_a = brush_alpha_i;
        op_b = opacity_i;
      end
      FUNC_MASK_BRUSH: begin
        op_a = opacity_i;
        op_b = brush_alpha_i;
      end
      FUNC_MASK_PAINT: begin
        op_a = s_src_alpha_i;
        op_b = s_carry_i.mask;
      end
      default: begin
        op_a = s_src_alpha_i;
        op_b = opacity_i;
      end
    endcase
  end
  assign m1_d = 16'(op_a) * 16'(op_b);

  // stage 3: mask times scaled brush alpha, or first divide of the triple product
  assign x3_d = (c2_q.func == FUNC_MASK_BRUSH) ? 16'(c2_q.mask) * 16'(q2_q)
                                               : div255_24(p3_q);

  // stage 4: final effective alpha and flags
  always_comb begin
    if (c3_q.func == FUNC_IMAGE || c3_q.func == FUNC_SOLID) begin
      a4 = q3_q;
    end else begin
      a4 = div255_16(x3_q);
    end
    case (c3_q.func)
      FUNC_IMAGE: act4 = c3_q.src_nz;
      FUNC_SOLID: act4 = (a4 != ALPHA_CLEAR);
      default:    act4 = (c3_q.mask != ALPHA_CLEAR);
    endcase
    req_d.color = c3_q.color;
    req_d.dst   = c3_q.dst;
    req_d.alpha = a4;
    req_d.full  = (a4 == ALPHA_OPAQUE);
    req_d.act   = act4;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q <= s_carry_i;
      m1_q <= m1_d;
    end
    if (en2) begin
      c2_q <= c1_q;
      q2_q <= div255_16(m1_q);
      p3_q <= 24'(m1_q) * 24'(opacity_i);
    end
    if (en3) begin
      c3_q <= c2_q;
      q3_q <= q2_q;
      x3_q <= x3_d;
    end
    if (en4) begin
      req_q <= req_d;
    end
  end

  assign m_valid_o = v4_q;
  assign m_req_o   = req_q;

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (req_q.full == (req_q.alpha == ALPHA_OPAQUE)))
    else $error("full flag does not match effective alpha");

  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !m_ready_i) |=> (v4_q && $stable(req_q)))
    else $error("stalled alpha result lost or changed");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en4) |=> v3_q)
    else $error("stage 3 item dropped during stall");

endmodule

>>> design/rsob_blend.sv
module rsob_blend import rsob_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  blend_req_t s_req_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output pix_t       m_pix_o,
  output logic       m_written_o
);

  logic v5_q, v6_q;
  logic en5, en6;
  logic [15:0] sum_r_d, sum_g_d, sum_b_d;
  logic [15:0] sum_r_q, sum_g_q, sum_b_q;
  logic [7:0]  inv_a;
  logic [7:0]  alpha5_d, alpha5_q;
  logic        full5_q, act5_q;
  rgb_t        color5_q;
  rgb_t        dst5_q;
  pix_t        pix6_d, pix6_q;
  logic        wr6_q;

  assign en6 = !v6_q || m_ready_i;
  assign en5 = !v5_q || en6;
  assign s_ready_o = en5;

  // stage 5: weighted sums a*s + (255-a)*d
  assign inv_a   = ~s_req_i.alpha;
  assign sum_r_d = 16'(s_req_i.alpha) * 16'(s_req_i.color.red)
                 + 16'(inv_a) * 16'(s_req_i.dst.red);
  assign sum_g_d = 16'(s_req_i.alpha) * 16'(s_req_i.color.green)
                 + 16'(inv_a) * 16'(s_req_i.dst.green);
  assign sum_b_d = 16'(s_req_i.alpha) * 16'(s_req_i.color.blue)
                 + 16'(inv_a) * 16'(s_req_i.dst.blue);

  // result alpha: opaque on replace, max on blend, pass on skip
  always_comb begin
    if (s_req_i.full) begin
      alpha5_d = ALPHA_OPAQUE;
    end else if (s_req_i.act && (s_req_i.alpha > s_req_i.dst.alpha)) begin
      alpha5_d = s_req_i.alpha;
    end else begin
      alpha5_d = s_req_i.dst.alpha;
    end
  end

  // stage 6: divide and select
  always_comb begin
    if (full5_q) begin
      pix6_d.red   = color5_q.red;
      pix6_d.green = color5_q.green;
      pix6_d.blue  = color5_q.blue;
    end else if (act5_q) begin
      pix6_d.red   = div255_16(sum_r_q);
      pix6_d.green = div255_16(sum_g_q);
      pix6_d.blue  = div255_16(sum_b_q);
    end else begin
      pix6_d.red   = dst5_q.red;
      pix6_d.green = dst5_q.green;
      pix6_d.blue  = dst5_q.blue;
    end
    pix6_d.alpha = alpha5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= s_valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      sum_r_q  <= sum_r_d;
      sum_g_q  <= sum_g_d;
      sum_b_q  <= sum_b_d;
      alpha5_q <= alpha5_d;
      full5_q  <= s_req_i.full;
      act5_q   <= s_req_i.act;
      color5_q <= s_req_i.color;
      dst5_q   <= '{red: s_req_i.dst.red, green: s_req_i.dst.green,
                    blue: s_req_i.dst.blue};
    end
    if (en6) begin
      pix6_q <= pix6_d;
      wr6_q  <= full5_q || act5_q;
    end
  end

  assign m_valid_o   = v6_q;
  assign m_pix_o     = pix6_q;
  assign m_written_o = wr6_q;

  a_opaque_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && en6 && full5_q) |=> (v6_q && wr6_q && pix6_q.alpha == ALPHA_OPAQUE))
    else $error("replaced pixel not opaque or not written");

  a_skip_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && en5 && !s_req_i.full && !s_req_i.act)
      |=> (alpha5_q == $past(s_req_i.dst.alpha)))
    else $error("skipped pixel alpha altered");

  a_blend_alpha_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && en5 && s_req_i.act) |=> (alpha5_q >= $past(s_req_i.alpha)))
    else $error("blended alpha below effective alpha");

endmodule

>>> design/rgba_source_over_pixel_blender.sv
// Source-over blender for RGBA8888 pixels. One pixel per clock enters and
// leaves at full rate while the output is not stalled; each pixel passes
// through six register stages (four that form the effective alpha with
// multiply-by-reciprocal divides by 255, two that form and divide the
// per-channel weighted sums). Ready travels back stage by stage,
// so bubbles are squeezed out during a stall. Configuration registers are
// read live by the pipeline and must only be written while it is empty.
module rgba_source_over_pixel_blender import rsob_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  rsob_in_if.sink            pix_in,
  rsob_out_if.source         pix_out
);

  logic [7:0] opacity_q;
  logic [7:0] brush_alpha_q;
  rgb_t       brush_q;
  carry_t     carry_in;
  logic       req_valid, req_ready;
  blend_req_t req;
  pix_t       res_pix;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q     <= ALPHA_OPAQUE;
      brush_q       <= '0;
      brush_alpha_q <= ALPHA_OPAQUE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OPACITY: opacity_q       <= cfg_wdata_i;
        REG_BRUSH_R: brush_q.red     <= cfg_wdata_i;
        REG_BRUSH_G: brush_q.green   <= cfg_wdata_i;
        REG_BRUSH_B: brush_q.blue    <= cfg_wdata_i;
        REG_BRUSH_A: brush_alpha_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input pixel fields, source color chosen by func
  always_comb begin
    carry_in.func = func_e'(pix_in.func);
    if (carry_in.func == FUNC_IMAGE || carry_in.func == FUNC_MASK_PAINT) begin
      carry_in.color.red   = pix_in.src_red;
      carry_in.color.green = pix_in.src_green;
      carry_in.color.blue  = pix_in.src_blue;
    end else begin
      carry_in.color = brush_q;
    end
    carry_in.mask      = pix_in.mask_alpha;
    carry_in.src_nz    = (pix_in.src_alpha != ALPHA_CLEAR);
    carry_in.dst.red   = pix_in.dst_red;
    carry_in.dst.green = pix_in.dst_green;
    carry_in.dst.blue  = pix_in.dst_blue;
    carry_in.dst.alpha = pix_in.dst_alpha;
  end

  rsob_alpha u_alpha (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opacity_i     (opacity_q),
    .brush_alpha_i (brush_alpha_q),
    .s_valid_i     (pix_in.valid),
    .s_ready_o     (pix_in.ready),
    .s_carry_i     (carry_in),
    .s_src_alpha_i (pix_in.src_alpha),
    .m_valid_o     (req_valid),
    .m_ready_i     (req_ready),
    .m_req_o       (req)
  );

  rsob_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (req_valid),
    .s_ready_o   (req_ready),
    .s_req_i     (req),
    .m_valid_o   (pix_out.valid),
    .m_ready_i   (pix_out.ready),
    .m_pix_o     (res_pix),
    .m_written_o (pix_out.written)
  );

  assign pix_out.out_red   = res_pix.red;
  assign pix_out.out_green = res_pix.green;
  assign pix_out.out_blue  = res_pix.blue;
  assign pix_out.out_alpha = res_pix.alpha;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rsob_pkg::*;

  localparam int unsigned HANG_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned HOLD_CYC    = 200;

  // one pixel offered to the blender
  typedef struct {
    func_e      func;
    pix_t       src;
    logic [7:0] mask;
    pix_t       dst;
  } pixel_item_t;

  // one blended pixel as it leaves the blender
  typedef struct packed {
    pix_t pix;
    logic written;
  } blend_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [7:0]        cfg_wdata;

  rsob_in_if  pix_in_if ();
  rsob_out_if pix_out_if ();

  rgba_source_over_pixel_blender DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_in      (pix_in_if),
    .pix_out     (pix_out_if)
  );

  // shadow copy of the blender registers
  logic [7:0]    reg_shadow [0:4];
  blend_result_t blend_expect_q [$];
  blend_result_t exp_pix;
  int unsigned   err_count;
  int unsigned   idle_cycles;
  bit            tx_idle_en;
  bit            rx_idle_en;
  bit            rx_hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // golden blend of one pixel under the current register values
  function automatic logic [7:0] weigh_channel(int unsigned a, int unsigned s,
                                               int unsigned d);
    return 8'((a * s + (255 - a) * d) / 255);
  endfunction

  function automatic blend_result_t blend_pixel(pixel_item_t it);
    int unsigned   o;
    int unsigned   ba;
    int unsigned   sa;
    int unsigned   mk;
    int unsigned   a;
    logic [7:0]    cr;
    logic [7:0]    cg;
    logic [7:0]    cb;
    bit            act;
    blend_result_t r;
    o  = 32'(reg_shadow[REG_OPACITY]);
    ba = 32'(reg_shadow[REG_BRUSH_A]);
    sa = 32'(it.src.alpha);
    mk = 32'(it.mask);
    // image and paint modes take the source color, the others the brush
    if (it.func == FUNC_IMAGE || it.func == FUNC_MASK_PAINT) begin
      cr = it.src.red;
      cg = it.src.green;
      cb = it.src.blue;
    end else begin
      cr = reg_shadow[REG_BRUSH_R];
      cg = reg_shadow[REG_BRUSH_G];
      cb = reg_shadow[REG_BRUSH_B];
    end
    case (it.func)
      FUNC_IMAGE: begin
        a   = sa * o / 255;
        act = (sa != 0);
      end
      FUNC_SOLID: begin
        a   = ba * o / 255;
        act = (a != 0);
      end
      FUNC_MASK_BRUSH: begin
        a   = mk * (o * ba / 255) / 255;
        act = (mk != 0);
      end
      default: begin
        a   = sa * mk * o / (255 * 255);
        act = (mk != 0);
      end
    endcase
    a = a & 32'hFF;
    if (a == 255) begin
      r.pix     = '{red: cr, green: cg, blue: cb, alpha: ALPHA_OPAQUE};
      r.written = 1'b1;
    end else if (act) begin
      r.pix.red   = weigh_channel(a, 32'(cr), 32'(it.dst.red));
      r.pix.green = weigh_channel(a, 32'(cg), 32'(it.dst.green));
      r.pix.blue  = weigh_channel(a, 32'(cb), 32'(it.dst.blue));
      r.pix.alpha = (32'(it.dst.alpha) > a) ? it.dst.alpha : 8'(a);
      r.written   = 1'b1;
    end else begin
      r.pix     = it.dst;
      r.written = 1'b0;
    end
    return r;
  endfunction

  // levels biased toward the ends of the range
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return ALPHA_CLEAR;
      1: return ALPHA_OPAQUE;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_item_t make_item(func_e f, int sr, int sg, int sb, int sa,
                                            int mk, int dr, int dg, int db, int da);
    pixel_item_t it;
    it.func = f;
    it.src  = '{red: 8'(sr), green: 8'(sg), blue: 8'(sb), alpha: 8'(sa)};
    it.mask = 8'(mk);
    it.dst  = '{red: 8'(dr), green: 8'(dg), blue: 8'(db), alpha: 8'(da)};
    return it;
  endfunction

  function automatic pixel_item_t random_item();
    return make_item(func_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     int'(pick_level()), int'(pick_level()), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     int'(pick_level()));
  endfunction

  // offer one pixel and wait for its transfer, then maybe pause
  task automatic push_pixel(input pixel_item_t it);
    pix_in_if.valid      <= 1'b1;
    pix_in_if.func       <= it.func;
    pix_in_if.src_red    <= it.src.red;
    pix_in_if.src_green  <= it.src.green;
    pix_in_if.src_blue   <= it.src.blue;
    pix_in_if.src_alpha  <= it.src.alpha;
    pix_in_if.mask_alpha <= it.mask;
    pix_in_if.dst_red    <= it.dst.red;
    pix_in_if.dst_green  <= it.dst.green;
    pix_in_if.dst_blue   <= it.dst.blue;
    pix_in_if.dst_alpha  <= it.dst.alpha;
    @(posedge clk);
    while (!pix_in_if.ready) @(posedge clk);
    blend_expect_q.push_back(blend_pixel(it));
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      pix_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // stop offering and let the pipeline empty
  task automatic settle_pipeline();
    pix_in_if.valid <= 1'b0;
    while (blend_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    reg_shadow[idx] = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] o, input logic [7:0] br,
                              input logic [7:0] bg, input logic [7:0] bb,
                              input logic [7:0] ba);
    settle_pipeline();
    write_reg(REG_OPACITY, o);
    write_reg(REG_BRUSH_R, br);
    write_reg(REG_BRUSH_G, bg);
    write_reg(REG_BRUSH_B, bb);
    write_reg(REG_BRUSH_A, ba);
  endtask

  // corner pixels of every source mode under a few register settings
  task automatic test_directed_corners();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // reset settings: full opacity, opaque black brush
    push_pixel(make_item(FUNC_IMAGE, 200, 100, 50, 255, 165, 1, 2, 3, 4));
    push_pixel(make_item(FUNC_IMAGE, 90, 91, 92, 0, 77, 255, 255, 255, 255));
    push_pixel(make_item(FUNC_IMAGE, 255, 0, 255, 128, 0, 0, 255, 0, 0));
    push_pixel(make_item(FUNC_SOLID, 12, 34, 56, 78, 90, 200, 150, 100, 50));
    push_pixel(make_item(FUNC_MASK_BRUSH, 255, 255, 255, 255, 0, 10, 20, 30, 40));
    push_pixel(make_item(FUNC_MASK_BRUSH, 1, 2, 3, 4, 255, 99, 88, 77, 66));
    push_pixel(make_item(FUNC_MASK_BRUSH, 0, 0, 0, 0, 77, 255, 128, 64, 32));
    push_pixel(make_item(FUNC_MASK_PAINT, 50, 60, 70, 255, 0, 1, 1, 1, 1));
    push_pixel(make_item(FUNC_MASK_PAINT, 255, 255, 255, 255, 255, 0, 0, 0, 0));
    // coverage so thin that the alpha truncates away
    push_pixel(make_item(FUNC_MASK_PAINT, 255, 255, 255, 1, 1, 17, 18, 19, 20));
    push_pixel(make_item(FUNC_MASK_PAINT, 255, 0, 255, 0, 200, 5, 6, 7, 8));
    // faint opacity: most alphas vanish; image and mask pixels still count as drawn, solid ones do not
    apply_config(8'd1, 8'd255, 8'd128, 8'd7, 8'd200);
    push_pixel(make_item(FUNC_IMAGE, 255, 255, 255, 255, 0, 0, 0, 0, 0));
    push_pixel(make_item(FUNC_IMAGE, 255, 255, 255, 254, 255, 40, 50, 60, 70));
    push_pixel(make_item(FUNC_SOLID, 0, 0, 0, 0, 0, 33, 44, 55, 66));
    push_pixel(make_item(FUNC_MASK_BRUSH, 0, 0, 0, 0, 255, 100, 110, 120, 130));
    // opacity and brush alpha at zero
    apply_config(8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    push_pixel(make_item(FUNC_IMAGE, 255, 255, 255, 255, 255, 1, 2, 3, 4));
    push_pixel(make_item(FUNC_SOLID, 255, 255, 255, 255, 255, 9, 8, 7, 6));
    // almost opaque brush
    apply_config(8'd255, 8'd10, 8'd20, 8'd30, 8'd254);
    push_pixel(make_item(FUNC_SOLID, 0, 0, 0, 0, 0, 255, 255, 255, 255));
    push_pixel(make_item(FUNC_MASK_BRUSH, 7, 7, 7, 7, 255, 0, 128, 255, 100));
    push_pixel(make_item(FUNC_IMAGE, 255, 255, 255, 255, 255, 0, 0, 0, 0));
    push_pixel(make_item(FUNC_IMAGE, 0, 0, 0, 254, 0, 255, 255, 255, 255));
  endtask

  // random pixels over a series of register settings
  task automatic test_random_blend();
    logic [7:0] o;
    logic [7:0] ba;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin o = 8'd0;   ba = pick_level(); end
        1: begin o = 8'd255; ba = 8'd255;       end
        2: begin o = 8'd255; ba = 8'd0;         end
        default: begin o = pick_level(); ba = pick_level(); end
      endcase
      apply_config(o, pick_level(), pick_level(), pick_level(), ba);
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      repeat (90) push_pixel(random_item());
    end
  endtask

  // receiver holds off while pixels keep coming, so the pipeline backs up
  task automatic test_backpressure();
    settle_pipeline();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (48) push_pixel(random_item());
    settle_pipeline();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (60) push_pixel(random_item());
  endtask

  // main sequence
  initial begin : main
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_OPACITY;
    cfg_wdata            <= 8'd0;
    pix_in_if.valid      <= 1'b0;
    pix_in_if.func       <= FUNC_IMAGE;
    pix_in_if.src_red    <= 8'd0;
    pix_in_if.src_green  <= 8'd0;
    pix_in_if.src_blue   <= 8'd0;
    pix_in_if.src_alpha  <= 8'd0;
    pix_in_if.mask_alpha <= 8'd0;
    pix_in_if.dst_red    <= 8'd0;
    pix_in_if.dst_green  <= 8'd0;
    pix_in_if.dst_blue   <= 8'd0;
    pix_in_if.dst_alpha  <= 8'd0;
    reg_shadow[REG_OPACITY] = 8'd255;
    reg_shadow[REG_BRUSH_R] = 8'd0;
    reg_shadow[REG_BRUSH_G] = 8'd0;
    reg_shadow[REG_BRUSH_B] = 8'd0;
    reg_shadow[REG_BRUSH_A] = 8'd255;
    err_count   = 0;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_blend();
    test_backpressure();
    test_full_rate_tail();

    pix_in_if.valid <= 1'b0;
    while (blend_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (blend_expect_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected pixels never arrived", $time, blend_expect_q.size());
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: random stalls, and one long hold-off on request
  initial begin : receiver
    pix_out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        pix_out_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        pix_out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        pix_out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // compare each result transfer with the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && pix_out_if.valid && pix_out_if.ready) begin
      if (blend_expect_q.size() == 0) begin
        err_count++;
        $display("%0t: pixel expected none got %0d %0d %0d %0d written %0d", $time,
                 pix_out_if.out_red, pix_out_if.out_green, pix_out_if.out_blue,
                 pix_out_if.out_alpha, pix_out_if.written);
      end else begin
        exp_pix = blend_expect_q.pop_front();
        check_field("out_red",   exp_pix.pix.red,   pix_out_if.out_red);
        check_field("out_green", exp_pix.pix.green, pix_out_if.out_green);
        check_field("out_blue",  exp_pix.pix.blue,  pix_out_if.out_blue);
        check_field("out_alpha", exp_pix.pix.alpha, pix_out_if.out_alpha);
        check_field("written",   8'(exp_pix.written), 8'(pix_out_if.written));
      end
    end
  end

  // watchdog: too long without any transfer on either side
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> rgba_source_over_pixel_blender.f
design/rsob_pkg.sv
design/rsob_if.sv
design/rsob_alpha.sv
design/rsob_blend.sv
design/rgba_source_over_pixel_blender.sv
tb/testbench.sv
